// ===== rtl/core/tlma_pkg.sv =====
// Shared types and constants for the tetrahedron lumped-mass assembly block.
package tlma_pkg;

    // Fixed field widths of the channels.
    localparam int IDX_W   = 12;
    localparam int COORD_W = 16;
    localparam int MASS_W  = 63;
    localparam int DENS_W  = 8;

    // Largest representable node mass; sums above it clamp here.
    localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};

    // Reset value of the density register.
    localparam logic [DENS_W-1:0] DENS_RESET = 8'd1;

    // Division of the scaled volume by three, one byte per step.
    localparam int DIV_W       = 64;
    localparam int DIV_STEPS   = DIV_W / 8;
    localparam int DIVISOR     = 3;
    localparam int RECIP_3     = 683;
    localparam int RECIP_SHIFT = 11;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_READ,
        ST_UPD,
        ST_OUT
    } state_t;

    // Multiply-accumulate steps of the determinant and the density scaling.
    typedef enum logic [3:0] {
        OP_A_HI,
        OP_A_LO,
        OP_B_HI,
        OP_B_LO,
        OP_C_HI,
        OP_C_LO,
        OP_D_A,
        OP_D_B,
        OP_D_C,
        OP_SCALE
    } op_t;

endpackage

// ===== rtl/core/tlma_if.sv =====
// Channel interfaces of the lumped-mass assembly block: corners, results, density writes.
interface tlma_corner_if;
    logic                             valid;
    logic                             ready;
    logic [tlma_pkg::IDX_W-1:0]       node_index;
    logic [tlma_pkg::COORD_W-1:0]     coord_x;
    logic [tlma_pkg::COORD_W-1:0]     coord_y;
    logic [tlma_pkg::COORD_W-1:0]     coord_z;

    modport source (output valid, node_index, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, node_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface tlma_result_if;
    logic                             valid;
    logic                             ready;
    logic [tlma_pkg::IDX_W-1:0]       node_index_res;
    logic [tlma_pkg::MASS_W-1:0]      total_mass;
    logic                             last_of_element;

    modport source (output valid, node_index_res, total_mass, last_of_element, input ready);
    modport sink   (input valid, node_index_res, total_mass, last_of_element, output ready);
endinterface

interface tlma_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tlma_pkg::DENS_W-1:0]      density;

    modport source (output valid, density, input ready);
    modport sink   (input valid, density, output ready);
endinterface

// ===== rtl/core/tetra_lumped_mass_assembly.sv =====
// Lumped-mass assembly for linear tetrahedra with a shared multiplier and a mass memory.
//
// Usage: the four corners of one tetrahedron arrive as beats on the corner channel.
// The first three are held and accepted one per cycle. On the fourth, one signed
// multiplier, shared over ten multiply and accumulate steps, each a multiply state
// and an accumulate state, forms the 3x3 edge determinant and scales its magnitude by
// density. A byte-per-cycle divider by three then yields the per-corner share. Each
// corner then takes a read-modify-write of the mass memory in read, update and output
// states, the last of which carries its result beat. The block stays busy through
// any output stall; the next element's corners are refused until the fourth result
// beat is taken.
// The result register holds its beat until the receiver takes it; a stalled receiver
// simply holds the sequencer in place.
// The density register is written through the cfg channel, one beat per write, and
// is always ready. It resets to one.
// After reset the block clears the mass memory, one entry per cycle, and corners are
// refused during that pass.
// Node indices at or above NODE_COUNT leave the memory alone and report zero mass.
module tetra_lumped_mass_assembly #(
    parameter int NODE_COUNT = 4096,
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tlma_cfg_if.sink    cfg,
    tlma_corner_if.sink corner,
    tlma_result_if.source result
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int WW = ((AW > tlma_pkg::IDX_W) ? AW : tlma_pkg::IDX_W) + 1;
    localparam int EW = COORD_BITS + 1;
    localparam int DW = 3 * EW + 2;
    localparam int PW = EW + DW;
    localparam int CW = $clog2(tlma_pkg::DIV_STEPS);

    // Sequencer state.
    tlma_pkg::state_t state_reg, state_next;
    tlma_pkg::op_t    op_reg;

    logic [AW-1:0]                    clr_cnt_reg;
    logic [tlma_pkg::DENS_W-1:0]      density_reg;
    logic [1:0]                       corner_count_reg;
    logic signed [COORD_BITS-1:0]     corner_coord_reg [3][3];
    logic [tlma_pkg::IDX_W-1:0]       corner_idx_reg [4];
    logic signed [EW-1:0]             edge_reg [3][3];
    logic signed [PW-1:0]             prod_reg;
    logic signed [PW-1:0]             acc_reg;
    logic signed [DW-1:0]             minor_reg [3];
    logic [DW-1:0]                    dabs_reg;
    logic [tlma_pkg::DIV_W-1:0]       div_reg;
    logic [1:0]                       rem_reg;
    logic [CW-1:0]                    div_cnt_reg;
    logic [1:0]                       sel_reg;
    logic [tlma_pkg::MASS_W-1:0]      rd_data_reg;
    logic [tlma_pkg::IDX_W-1:0]       out_idx_reg;
    logic [tlma_pkg::MASS_W-1:0]      out_mass_reg;
    logic                             out_last_reg;

    logic [tlma_pkg::MASS_W-1:0]      mass_mem [NODE_COUNT];

    logic                             corner_acc;
    logic                             result_acc;
    logic signed [COORD_BITS-1:0]     p_coord [3];
    logic signed [EW-1:0]             mul_a;
    logic signed [DW-1:0]             mul_b;
    logic signed [PW-1:0]             mul_p;
    logic signed [PW-1:0]             acc_new;
    logic signed [PW-1:0]             acc_abs;
    logic [9:0]                       div_v;
    logic [19:0]                      div_prod;
    logic [7:0]                       div_q;
    logic [9:0]                       div_r;
    logic [tlma_pkg::IDX_W-1:0]       cur_idx;
    logic [WW-1:0]                    cur_idx_w;
    logic                             cur_in_range;
    logic [AW-1:0]                    cur_addr;
    logic [tlma_pkg::MASS_W:0]        mass_sum;
    logic [tlma_pkg::MASS_W-1:0]      mass_total;
    logic                             mem_we;
    logic                             mem_re;
    logic [AW-1:0]                    mem_wa;
    logic [tlma_pkg::MASS_W-1:0]      mem_wd;

    assign corner_acc = corner.valid && corner.ready;
    assign result_acc = result.valid && result.ready;

    // Only the low COORD_BITS bits of each coordinate count, taken as signed.
    assign p_coord[0] = $signed(corner.coord_x[COORD_BITS-1:0]);
    assign p_coord[1] = $signed(corner.coord_y[COORD_BITS-1:0]);
    assign p_coord[2] = $signed(corner.coord_z[COORD_BITS-1:0]);

    // Density register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg <= tlma_pkg::DENS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            density_reg <= cfg.density;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlma_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(NODE_COUNT - 1))
                begin
                    state_next = tlma_pkg::ST_IDLE;
                end
            end
            tlma_pkg::ST_IDLE:
            begin
                if (corner_acc && (corner_count_reg == 2'd3))
                begin
                    state_next = tlma_pkg::ST_MUL;
                end
            end
            tlma_pkg::ST_MUL:
            begin
                state_next = tlma_pkg::ST_ACC;
            end
            tlma_pkg::ST_ACC:
            begin
                state_next = (op_reg == tlma_pkg::OP_SCALE) ? tlma_pkg::ST_DIV
                                                            : tlma_pkg::ST_MUL;
            end
            tlma_pkg::ST_DIV:
            begin
                if (div_cnt_reg == '1)
                begin
                    state_next = tlma_pkg::ST_READ;
                end
            end
            tlma_pkg::ST_READ:
            begin
                state_next = tlma_pkg::ST_UPD;
            end
            tlma_pkg::ST_UPD:
            begin
                state_next = tlma_pkg::ST_OUT;
            end
            tlma_pkg::ST_OUT:
            begin
                if (result_acc)
                begin
                    state_next = (sel_reg == 2'd3) ? tlma_pkg::ST_IDLE : tlma_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = tlma_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlma_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Current corner of the read-modify-write pass and its memory address.
    assign cur_idx      = corner_idx_reg[sel_reg];
    assign cur_idx_w    = WW'(cur_idx);
    assign cur_in_range = (cur_idx_w < WW'(NODE_COUNT));
    assign cur_addr     = cur_idx_w[AW-1:0];

    // Saturating accumulation of the share into the node total.
    assign mass_sum   = {1'b0, rd_data_reg} + {1'b0, div_reg[tlma_pkg::MASS_W-1:0]};
    assign mass_total = mass_sum[tlma_pkg::MASS_W] ? tlma_pkg::MASS_MAX
                                                   : mass_sum[tlma_pkg::MASS_W-1:0];

    // Output logic: handshakes and memory port controls.
    always_comb
    begin
        corner.ready = 1'b0;
        result.valid = 1'b0;
        cfg.ready    = 1'b1;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wa       = cur_addr;
        mem_wd       = mass_total;
        case (state_reg)
            tlma_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = '0;
            end
            tlma_pkg::ST_IDLE:
            begin
                corner.ready = 1'b1;
            end
            tlma_pkg::ST_READ:
            begin
                mem_re = 1'b1;
            end
            tlma_pkg::ST_UPD:
            begin
                mem_we = cur_in_range;
            end
            tlma_pkg::ST_OUT:
            begin
                result.valid = 1'b1;
            end
            default:
            begin
                corner.ready = 1'b0;
            end
        endcase
    end

    assign result.node_index_res  = out_idx_reg;
    assign result.total_mass      = out_mass_reg;
    assign result.last_of_element = out_last_reg;

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == tlma_pkg::ST_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Corner count, the control part of corner capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_count_reg <= '0;
        end
        else if (corner_acc)
        begin
            corner_count_reg <= corner_count_reg + 2'd1;
        end
    end

    // Corner capture and edge vectors from corner 0 on the fourth corner.
    always_ff @(posedge clk)
    begin
        if (corner_acc)
        begin
            if (corner_count_reg != 2'd3)
            begin
                corner_idx_reg[corner_count_reg] <= corner.node_index;
                for (int c = 0; c < 3; c++)
                begin
                    corner_coord_reg[corner_count_reg][c] <= p_coord[c];
                end
            end
            else
            begin
                corner_idx_reg[3] <= corner.node_index;
                for (int c = 0; c < 3; c++)
                begin
                    edge_reg[0][c] <= EW'(corner_coord_reg[1][c]) - EW'(corner_coord_reg[0][c]);
                    edge_reg[1][c] <= EW'(corner_coord_reg[2][c]) - EW'(corner_coord_reg[0][c]);
                    edge_reg[2][c] <= EW'(p_coord[c]) - EW'(corner_coord_reg[0][c]);
                end
            end
        end
    end

    // Operand selection of the shared multiplier for each step.
    always_comb
    begin
        case (op_reg)
            tlma_pkg::OP_A_HI:
            begin
                mul_a = edge_reg[1][1];
                mul_b = DW'(edge_reg[2][2]);
            end
            tlma_pkg::OP_A_LO:
            begin
                mul_a = edge_reg[1][2];
                mul_b = DW'(edge_reg[2][1]);
            end
            tlma_pkg::OP_B_HI:
            begin
                mul_a = edge_reg[1][0];
                mul_b = DW'(edge_reg[2][2]);
            end
            tlma_pkg::OP_B_LO:
            begin
                mul_a = edge_reg[1][2];
                mul_b = DW'(edge_reg[2][0]);
            end
            tlma_pkg::OP_C_HI:
            begin
                mul_a = edge_reg[1][0];
                mul_b = DW'(edge_reg[2][1]);
            end
            tlma_pkg::OP_C_LO:
            begin
                mul_a = edge_reg[1][1];
                mul_b = DW'(edge_reg[2][0]);
            end
            tlma_pkg::OP_D_A:
            begin
                mul_a = edge_reg[0][0];
                mul_b = minor_reg[0];
            end
            tlma_pkg::OP_D_B:
            begin
                mul_a = edge_reg[0][1];
                mul_b = minor_reg[1];
            end
            tlma_pkg::OP_D_C:
            begin
                mul_a = edge_reg[0][2];
                mul_b = minor_reg[2];
            end
            tlma_pkg::OP_SCALE:
            begin
                mul_a = EW'($signed({1'b0, density_reg}));
                mul_b = $signed(dabs_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Accumulator update: start fresh, subtract or add the registered product.
    always_comb
    begin
        case (op_reg)
            tlma_pkg::OP_A_LO, tlma_pkg::OP_B_LO, tlma_pkg::OP_C_LO, tlma_pkg::OP_D_B:
            begin
                acc_new = acc_reg - prod_reg;
            end
            tlma_pkg::OP_D_C:
            begin
                acc_new = acc_reg + prod_reg;
            end
            default:
            begin
                acc_new = prod_reg;
            end
        endcase
    end

    assign acc_abs = (acc_new < 0) ? -acc_new : acc_new;

    // One byte of the division by three: a reciprocal multiply and a remainder.
    assign div_v    = {rem_reg, div_reg[tlma_pkg::DIV_W-1 -: 8]};
    assign div_prod = 20'(div_v) * 20'(tlma_pkg::RECIP_3);
    assign div_q    = div_prod[tlma_pkg::RECIP_SHIFT +: 8];
    assign div_r    = div_v - 10'(div_q) * 10'(tlma_pkg::DIVISOR);

    // Step counters of the multiply and divide loops.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= tlma_pkg::OP_A_HI;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (corner_acc)
            begin
                op_reg <= tlma_pkg::OP_A_HI;
            end
            else if ((state_reg == tlma_pkg::ST_ACC) && (op_reg != tlma_pkg::OP_SCALE))
            begin
                op_reg <= tlma_pkg::op_t'(op_reg + 4'd1);
            end
            if (state_reg == tlma_pkg::ST_ACC)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == tlma_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + CW'(1);
            end
        end
    end

    // Multiply-accumulate and divide datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == tlma_pkg::ST_MUL)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == tlma_pkg::ST_ACC)
        begin
            acc_reg <= acc_new;
            case (op_reg)
                tlma_pkg::OP_A_LO:
                begin
                    minor_reg[0] <= DW'(acc_new);
                end
                tlma_pkg::OP_B_LO:
                begin
                    minor_reg[1] <= DW'(acc_new);
                end
                tlma_pkg::OP_C_LO:
                begin
                    minor_reg[2] <= DW'(acc_new);
                end
                tlma_pkg::OP_D_C:
                begin
                    dabs_reg <= DW'(acc_abs);
                end
                tlma_pkg::OP_SCALE:
                begin
                    // Drop three bits for the factor eight; the divider handles three.
                    div_reg <= tlma_pkg::DIV_W'(prod_reg[PW-1:3]);
                    rem_reg <= '0;
                end
                default:
                begin
                    rem_reg <= rem_reg;
                end
            endcase
        end
        else if (state_reg == tlma_pkg::ST_DIV)
        begin
            div_reg <= {div_reg[tlma_pkg::DIV_W-9:0], div_q};
            rem_reg <= div_r[1:0];
        end
    end

    // Corner selector of the read-modify-write pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= '0;
        end
        else if (corner_acc)
        begin
            sel_reg <= '0;
        end
        else if (result_acc)
        begin
            sel_reg <= sel_reg + 2'd1;
        end
    end

    // Result register, loaded on the update cycle and held until taken.
    always_ff @(posedge clk)
    begin
        if (state_reg == tlma_pkg::ST_UPD)
        begin
            out_idx_reg  <= cur_idx;
            out_mass_reg <= cur_in_range ? mass_total : '0;
            out_last_reg <= (sel_reg == 2'd3);
        end
    end

    // Mass memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mass_mem[mem_wa] <= mem_wd;
        end
    end

    // Mass memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mass_mem[cur_addr];
        end
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the tetrahedron lumped-mass assembly block.
`timescale 1ns / 100ps

module testbench;

    // Traffic shaping used in each phase of the run.
    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH
    } flow_t;

    // One expected result beat.
    typedef struct {
        logic [tlma_pkg::IDX_W-1:0]  node;
        logic [tlma_pkg::MASS_W-1:0] mass;
        logic                        last;
    } node_total_t;

    localparam int NODES        = 4096;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_WAIT  = 60;
    localparam logic [tlma_pkg::COORD_W-1:0] COORD_LO = 16'h8000;
    localparam logic [tlma_pkg::COORD_W-1:0] COORD_HI = 16'h7FFF;

    // Tracks held corners and node masses, and predicts the result beats.
    class lumped_mass_tracker;
        logic [tlma_pkg::DENS_W-1:0] density;
        longint                      held_x[3];
        longint                      held_y[3];
        longint                      held_z[3];
        logic [tlma_pkg::IDX_W-1:0]  held_idx[3];
        int                          held_count;
        logic [tlma_pkg::MASS_W-1:0] node_mass[NODES];
        node_total_t                 pending[$];
        int                          errors;

        function new();
            density    = tlma_pkg::DENS_RESET;
            held_count = 0;
            errors     = 0;
            foreach (node_mass[i])
                node_mass[i] = '0;
        endfunction

        // Called on every accepted corner beat.
        function void take_corner(logic [tlma_pkg::IDX_W-1:0] idx,
                                  logic [tlma_pkg::COORD_W-1:0] x,
                                  logic [tlma_pkg::COORD_W-1:0] y,
                                  logic [tlma_pkg::COORD_W-1:0] z);
            longint                      ex[3];
            longint                      ey[3];
            longint                      ez[3];
            longint                      px;
            longint                      py;
            longint                      pz;
            longint                      det;
            longint unsigned             magnitude;
            longint unsigned             share;
            longint unsigned             room;
            logic [tlma_pkg::IDX_W-1:0]  ids[4];
            logic [tlma_pkg::MASS_W-1:0] total;
            node_total_t                 beat;
            px = $signed(x);
            py = $signed(y);
            pz = $signed(z);
            if (held_count < 3)
            begin
                held_idx[held_count] = idx;
                held_x[held_count]   = px;
                held_y[held_count]   = py;
                held_z[held_count]   = pz;
                held_count++;
                return;
            end
            held_count = 0;

            // Edge vectors from the first corner; the determinant is exact in 64 bits.
            for (int r = 0; r < 3; r++)
            begin
                ex[r] = ((r < 2) ? held_x[r+1] : px) - held_x[0];
                ey[r] = ((r < 2) ? held_y[r+1] : py) - held_y[0];
                ez[r] = ((r < 2) ? held_z[r+1] : pz) - held_z[0];
            end
            det = ex[0] * (ey[1] * ez[2] - ez[1] * ey[2])
                - ey[0] * (ex[1] * ez[2] - ez[1] * ex[2])
                + ez[0] * (ex[1] * ey[2] - ey[1] * ex[2]);
            magnitude = (det < 0) ? longint'(-det) : longint'(det);
            share = (magnitude * longint'(density)) / 64'd24;

            ids[0] = held_idx[0];
            ids[1] = held_idx[1];
            ids[2] = held_idx[2];
            ids[3] = idx;

            // Saturating update of each corner in turn; repeated nodes add twice.
            for (int k = 0; k < 4; k++)
            begin
                total = '0;
                if (ids[k] < NODES)
                begin
                    room = {1'b0, tlma_pkg::MASS_MAX} - {1'b0, node_mass[ids[k]]};
                    if (share > room)
                        total = tlma_pkg::MASS_MAX;
                    else
                        total = node_mass[ids[k]] + share[tlma_pkg::MASS_W-1:0];
                    node_mass[ids[k]] = total;
                end
                beat.node = ids[k];
                beat.mass = total;
                beat.last = (k == 3);
                pending.push_back(beat);
            end
        endfunction

        // Called on every accepted result beat.
        function void match_total(logic [tlma_pkg::IDX_W-1:0] node,
                                  logic [tlma_pkg::MASS_W-1:0] mass, logic last);
            node_total_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat node %0d mass %0d last %0b",
                         $time, node, mass, last);
                return;
            end
            want = pending.pop_front();
            if (node !== want.node)
            begin
                errors++;
                $display("%0t: node_index_res expected %0d actual %0d",
                         $time, want.node, node);
            end
            if (mass !== want.mass)
            begin
                errors++;
                $display("%0t: total_mass of node %0d expected %0d actual %0d",
                         $time, want.node, want.mass, mass);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last_of_element of node %0d expected %0b actual %0b",
                         $time, want.node, want.last, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_gap_pct;
    int   recv_stall_pct;
    int   cycles;

    lumped_mass_tracker tracker = new();

    tlma_cfg_if    cfg_ch();
    tlma_corner_if corner_ch();
    tlma_result_if result_ch();

    tetra_lumped_mass_assembly dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .corner (corner_ch),
        .result (result_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result receiver: checks each taken beat and stalls at random.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                tracker.match_total(result_ch.node_index_res, result_ch.total_mass,
                                    result_ch.last_of_element);
            result_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic set_flow(input flow_t flow);
        send_gap_pct   = (flow == FLOW_SEND_GAPS) ? 53 : (flow == FLOW_BOTH) ? 18 : 0;
        recv_stall_pct = (flow == FLOW_RECV_STALLS) ? 53 : (flow == FLOW_BOTH) ? 18 : 0;
    endtask

    // Sends one corner beat, with random gaps ahead of it.
    task automatic put_corner(input logic [tlma_pkg::IDX_W-1:0] idx,
                              input logic [tlma_pkg::COORD_W-1:0] x,
                              input logic [tlma_pkg::COORD_W-1:0] y,
                              input logic [tlma_pkg::COORD_W-1:0] z);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            corner_ch.valid <= 1'b0;
            @(posedge clk);
        end
        corner_ch.valid      <= 1'b1;
        corner_ch.node_index <= idx;
        corner_ch.coord_x    <= x;
        corner_ch.coord_y    <= y;
        corner_ch.coord_z    <= z;
        do
            @(posedge clk);
        while (corner_ch.ready !== 1'b1);
        tracker.take_corner(idx, x, y, z);
    endtask

    // Largest tetrahedron in the coordinate cube; flip reverses its orientation.
    task automatic put_cube(input logic [tlma_pkg::IDX_W-1:0] a,
                            input logic [tlma_pkg::IDX_W-1:0] b,
                            input logic [tlma_pkg::IDX_W-1:0] c,
                            input logic [tlma_pkg::IDX_W-1:0] d,
                            input bit flip);
        put_corner(a, COORD_LO, COORD_LO, COORD_LO);
        if (flip)
        begin
            put_corner(b, COORD_HI, COORD_LO, COORD_HI);
            put_corner(c, COORD_HI, COORD_HI, COORD_LO);
        end
        else
        begin
            put_corner(b, COORD_HI, COORD_HI, COORD_LO);
            put_corner(c, COORD_HI, COORD_LO, COORD_HI);
        end
        put_corner(d, COORD_LO, COORD_HI, COORD_HI);
    endtask

    // Drops valid, waits for all pending beats and lets the block go idle.
    task automatic settle();
        corner_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_density(input logic [tlma_pkg::DENS_W-1:0] value);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.density <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        tracker.density = value;
    endtask

    // One random element in one of several shapes.
    task automatic random_element();
        logic [tlma_pkg::IDX_W-1:0]   ids[4];
        logic [tlma_pkg::COORD_W-1:0] xs[4];
        logic [tlma_pkg::COORD_W-1:0] ys[4];
        logic [tlma_pkg::COORD_W-1:0] zs[4];
        logic [tlma_pkg::COORD_W-1:0] base_x;
        logic [tlma_pkg::COORD_W-1:0] base_y;
        logic [tlma_pkg::COORD_W-1:0] base_z;
        int                           shape;
        shape  = int'($urandom_range(4));
        base_x = 16'($urandom);
        base_y = 16'($urandom);
        base_z = 16'($urandom);
        for (int k = 0; k < 4; k++)
        begin
            case (shape)
                // Small element around a random point, on a few shared nodes.
                0, 1:
                begin
                    ids[k] = 12'($urandom_range(7));
                    xs[k]  = base_x + 16'($urandom_range(63));
                    ys[k]  = base_y + 16'($urandom_range(63));
                    zs[k]  = base_z + 16'($urandom_range(63));
                end
                // Flat element: all corners in one plane.
                2:
                begin
                    ids[k] = 12'($urandom);
                    xs[k]  = 16'($urandom);
                    ys[k]  = 16'($urandom);
                    zs[k]  = base_z;
                end
                // Corners on the extremes of the coordinate range.
                3:
                begin
                    ids[k] = $urandom_range(1) ? 12'd4095 : 12'($urandom_range(3));
                    xs[k]  = $urandom_range(1) ? COORD_HI : COORD_LO;
                    ys[k]  = $urandom_range(1) ? COORD_HI : COORD_LO;
                    zs[k]  = $urandom_range(1) ? COORD_HI : COORD_LO;
                end
                default:
                begin
                    ids[k] = 12'($urandom);
                    xs[k]  = 16'($urandom);
                    ys[k]  = 16'($urandom);
                    zs[k]  = 16'($urandom);
                end
            endcase
        end
        for (int k = 0; k < 4; k++)
            put_corner(ids[k], xs[k], ys[k], zs[k]);
    endtask

    // Main sequence.
    initial
    begin
        logic [tlma_pkg::DENS_W-1:0] dens_plan[8];
        rst_n                = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.density       = '0;
        corner_ch.valid      = 1'b0;
        corner_ch.node_index = '0;
        corner_ch.coord_x    = '0;
        corner_ch.coord_y    = '0;
        corner_ch.coord_z    = '0;
        set_flow(FLOW_FREE);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed elements at the reset density.
        // Degenerate element: all corners on one point.
        put_corner(12'd5, 16'd1, 16'd2, 16'd3);
        put_corner(12'd6, 16'd1, 16'd2, 16'd3);
        put_corner(12'd7, 16'd1, 16'd2, 16'd3);
        put_corner(12'd8, 16'd1, 16'd2, 16'd3);
        // Unit element whose share rounds down to zero.
        put_corner(12'd0, 16'd0, 16'd0, 16'd0);
        put_corner(12'd1, 16'd1, 16'd0, 16'd0);
        put_corner(12'd2, 16'd0, 16'd1, 16'd0);
        put_corner(12'd3, 16'd0, 16'd0, 16'd1);
        // Largest elements in both orientations, with repeated node indices.
        put_cube(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b0);
        put_cube(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
        // Share of exactly one unit, first node repeated.
        put_corner(12'd10, 16'd0, 16'd0, 16'd0);
        put_corner(12'd11, 16'd24, 16'd0, 16'd0);
        put_corner(12'd12, 16'd0, 16'd1, 16'd0);
        put_corner(12'd10, 16'd0, 16'd0, 16'd1);
        // Mixed signs on every axis.
        put_corner(12'd100, COORD_LO, 16'hFFFF, 16'd0);
        put_corner(12'd101, COORD_HI, 16'd0, COORD_LO);
        put_corner(12'd102, 16'd0, COORD_HI, 16'd1);
        put_corner(12'd103, 16'hFFFF, COORD_LO, COORD_HI);
        settle();

        // Random phases, each writing a density and setting a traffic shape.
        dens_plan[0] = 8'd0;
        dens_plan[1] = 8'd255;
        dens_plan[2] = 8'($urandom_range(2, 254));
        dens_plan[3] = 8'd1;
        dens_plan[4] = 8'($urandom_range(2, 254));
        dens_plan[5] = 8'd255;
        dens_plan[6] = 8'd24;
        dens_plan[7] = 8'($urandom_range(2, 254));
        for (int phase = 0; phase < 8; phase++)
        begin
            write_density(dens_plan[phase]);
            set_flow(flow_t'(phase % 4));
            repeat (4 + phase % 2) random_element();
            settle();
        end

        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== tetra_lumped_mass_assembly.f =====
rtl/core/tlma_pkg.sv
rtl/core/tlma_if.sv
rtl/core/tetra_lumped_mass_assembly.sv
test/testbench.sv
